// ===== src/rts_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle shadow test package
// Shared widths, vector types and register indexes of the hit test pipeline.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int CW = 32;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int LW = 34;
    localparam int HW = XW - LW;
    localparam int MW = 101;
    localparam int SW = MW + 1;
    localparam int UW = SW - 1;
    localparam int FW = 16;
    localparam int QW = 31;
    localparam int NW = UW + FW;
    localparam int IW = 3;

    typedef logic signed [CW-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pt;

    typedef logic signed [DW-1:0] t_diff;
    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_vec;

    typedef logic signed [XW-1:0] t_xc;
    typedef struct packed {
        t_xc x;
        t_xc y;
        t_xc z;
    } t_xvec;

    typedef logic signed [SW-1:0] t_sum;
    typedef struct packed {
        t_sum den;
        t_sum nb;
        t_sum ng;
        t_sum nt;
    } t_dots;

    typedef logic [QW-1:0] t_q;
    localparam t_q MAX_Q = '1;
    localparam t_q MIN_DIST_RST = t_q'(7);

    typedef enum logic [IW-1:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_MIN_DIST
    } t_reg_idx;

endpackage

// ===== src/rts_cross.sv =====
// ----------------------------------------------------------------------------
// Edge and cross product stages
// Forms the edge vectors and the three cross products over three stages.
// ----------------------------------------------------------------------------
module rts_cross (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  rts_pkg::t_pt i_c0,
    input  rts_pkg::t_pt i_c1,
    input  rts_pkg::t_pt i_c2,
    input  rts_pkg::t_pt i_org,
    input  rts_pkg::t_pt i_dir,
    output logic        o_valid,
    input  logic        i_ready,
    output rts_pkg::t_vec  o_e1,
    output rts_pkg::t_vec  o_w,
    output rts_pkg::t_xvec o_c1,
    output rts_pkg::t_xvec o_c2,
    output rts_pkg::t_xvec o_c3
);
    import rts_pkg::*;

    localparam int NS = 3;

    function automatic t_vec vsub(t_pt a, t_pt b);
        t_vec r;
        r.x = DW'(a.x) - DW'(b.x);
        r.y = DW'(a.y) - DW'(b.y);
        r.z = DW'(a.z) - DW'(b.z);
        return r;
    endfunction

    function automatic logic signed [PW-1:0] mul(t_diff a, t_diff b);
        return PW'(a) * PW'(b);
    endfunction

    logic [NS-1:0]          r_v;
    logic [NS-1:0]          en;
    t_vec                   r_e1 [NS];
    t_vec                   r_w [NS];
    t_vec                   r_e2;
    logic signed [PW-1:0]   r_p [3][6];
    t_xvec                  r_x [3];
    t_vec                   dir;
    t_vec                   u [3];
    t_vec                   v [3];

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_comb begin
        dir.x = DW'(i_dir.x);
        dir.y = DW'(i_dir.y);
        dir.z = DW'(i_dir.z);
        u[0] = r_e2;
        v[0] = dir;
        u[1] = r_w[0];
        v[1] = dir;
        u[2] = r_e2;
        v[2] = r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_e1[0] <= vsub(i_c0, i_c1);
            r_e2    <= vsub(i_c0, i_c2);
            r_w[0]  <= vsub(i_c0, i_org);
        end
        if (en[1]) begin
            r_e1[1] <= r_e1[0];
            r_w[1]  <= r_w[0];
            for (int k = 0; k < 3; k++) begin
                r_p[k][0] <= mul(u[k].y, v[k].z);
                r_p[k][1] <= mul(u[k].z, v[k].y);
                r_p[k][2] <= mul(u[k].z, v[k].x);
                r_p[k][3] <= mul(u[k].x, v[k].z);
                r_p[k][4] <= mul(u[k].x, v[k].y);
                r_p[k][5] <= mul(u[k].y, v[k].x);
            end
        end
        if (en[2]) begin
            r_e1[2] <= r_e1[1];
            r_w[2]  <= r_w[1];
            for (int k = 0; k < 3; k++) begin
                r_x[k].x <= XW'(r_p[k][0]) - XW'(r_p[k][1]);
                r_x[k].y <= XW'(r_p[k][2]) - XW'(r_p[k][3]);
                r_x[k].z <= XW'(r_p[k][4]) - XW'(r_p[k][5]);
            end
        end
    end

    assign o_e1 = r_e1[2];
    assign o_w  = r_w[2];
    assign o_c1 = r_x[0];
    assign o_c2 = r_x[1];
    assign o_c3 = r_x[2];

endmodule

// ===== src/rts_dot.sv =====
// ----------------------------------------------------------------------------
// Dot product stages
// Forms the determinant and the three numerators from split partial products.
// ----------------------------------------------------------------------------
module rts_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rts_pkg::t_vec  i_e1,
    input  rts_pkg::t_vec  i_w,
    input  rts_pkg::t_xvec i_c1,
    input  rts_pkg::t_xvec i_c2,
    input  rts_pkg::t_xvec i_c3,
    output logic           o_valid,
    input  logic           i_ready,
    output rts_pkg::t_dots o_dots
);
    import rts_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0]          r_v;
    logic [NS-1:0]          en;
    t_diff                  a [4][3];
    t_xc                    c [4][3];
    logic signed [XW:0]     r_lo [4][3];
    logic signed [PW-1:0]   r_hi [4][3];
    logic signed [MW-1:0]   r_m [4][3];
    t_sum                   r_s [4];

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_comb begin
        a[0][0] = i_e1.x; a[0][1] = i_e1.y; a[0][2] = i_e1.z;
        c[0][0] = i_c1.x; c[0][1] = i_c1.y; c[0][2] = i_c1.z;
        a[1][0] = i_w.x;  a[1][1] = i_w.y;  a[1][2] = i_w.z;
        c[1][0] = i_c1.x; c[1][1] = i_c1.y; c[1][2] = i_c1.z;
        a[2][0] = i_e1.x; a[2][1] = i_e1.y; a[2][2] = i_e1.z;
        c[2][0] = i_c2.x; c[2][1] = i_c2.y; c[2][2] = i_c2.z;
        a[3][0] = i_e1.x; a[3][1] = i_e1.y; a[3][2] = i_e1.z;
        c[3][0] = i_c3.x; c[3][1] = i_c3.y; c[3][2] = i_c3.z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[d][k] <= (XW+1)'(a[d][k])
                                * $signed({(XW+1-LW)'(0), c[d][k][LW-1:0]});
                    r_hi[d][k] <= PW'(a[d][k]) * PW'($signed(c[d][k][XW-1:LW]));
                end
            end
        end
        if (en[1]) begin
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r_m[d][k] <= (MW'(r_hi[d][k]) <<< LW) + MW'(r_lo[d][k]);
                end
            end
        end
        if (en[2]) begin
            for (int d = 0; d < 4; d++) begin
                r_s[d] <= SW'(r_m[d][0]) + SW'(r_m[d][1]) + SW'(r_m[d][2]);
            end
        end
    end

    assign o_dots.den = r_s[0];
    assign o_dots.nb  = r_s[1];
    assign o_dots.ng  = r_s[2];
    assign o_dots.nt  = r_s[3];

endmodule

// ===== src/rts_div.sv =====
// ----------------------------------------------------------------------------
// Hit decision and distance divider
// Normalizes the sign, tests the barycentric bounds and divides one quotient
// bit per stage, then forms the result register.
// ----------------------------------------------------------------------------
module rts_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rts_pkg::t_dots i_dots,
    input  rts_pkg::t_q    i_min,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_hit,
    output rts_pkg::t_q    o_dist
);
    import rts_pkg::*;

    localparam int NS = QW + 3;
    localparam int RW = UW + QW;

    logic [NS-1:0]  r_v;
    logic [NS-1:0]  en;
    t_sum           r_den0;
    t_sum           r_nb0;
    t_sum           r_ng0;
    t_sum           r_nt0;
    logic           r_z;
    logic [NW-1:0]  r_rem [QW+1];
    logic [UW-1:0]  r_dd [QW+1];
    t_q             r_q [QW+1];
    logic           r_miss [QW+1];
    logic           r_sat [QW+1];
    logic           r_hit;
    t_q             r_dist;
    t_q             tq;
    logic           hit;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_z <= (i_dots.den == '0);
            if (i_dots.den < 0) begin
                r_den0 <= -i_dots.den;
                r_nb0  <= -i_dots.nb;
                r_ng0  <= -i_dots.ng;
                r_nt0  <= -i_dots.nt;
            end else begin
                r_den0 <= i_dots.den;
                r_nb0  <= i_dots.nb;
                r_ng0  <= i_dots.ng;
                r_nt0  <= i_dots.nt;
            end
        end
        if (en[1]) begin
            r_miss[0] <= r_z || (r_nb0 < 0) || (r_ng0 < 0) || (r_nt0 < 0)
                       || ((SW+1)'(r_den0) < (SW+1)'(r_nb0) + (SW+1)'(r_ng0));
            r_sat[0]  <= NW'(r_nt0[UW-1:0]) >= NW'({r_den0[UW-1:0], (QW-FW)'(0)});
            r_rem[0]  <= {r_nt0[UW-1:0], FW'(0)};
            r_dd[0]   <= r_den0[UW-1:0];
            r_q[0]    <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int B = QW - j;
        logic [RW-1:0] shd;
        logic          ge;

        assign shd = RW'(r_dd[j-1]) << B;
        assign ge  = RW'(r_rem[j-1]) >= shd;

        always_ff @(posedge i_clk) begin
            if (en[j+1]) begin
                r_rem[j]  <= ge ? NW'(RW'(r_rem[j-1]) - shd) : r_rem[j-1];
                r_q[j]    <= r_q[j-1] | (t_q'(ge) << B);
                r_dd[j]   <= r_dd[j-1];
                r_miss[j] <= r_miss[j-1];
                r_sat[j]  <= r_sat[j-1];
            end
        end
    end

    assign tq  = r_sat[QW] ? MAX_Q : r_q[QW];
    assign hit = !r_miss[QW] && (tq >= i_min);

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_hit  <= hit;
            r_dist <= hit ? tq : '0;
        end
    end

    assign o_hit  = r_hit;
    assign o_dist = r_dist;

endmodule

// ===== src/ray_triangle_shadow_test.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle shadow test
// Throughput is one triangle per cycle unless the output back-pressures; the
// 31-stage divider, one quotient bit per stage, sets the depth of the pipeline.
// Reset clears all valid bits and restores the ray registers to their
// defaults; there is no clearing pass and a beat is accepted right away.
// ----------------------------------------------------------------------------
module ray_triangle_shadow_test (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, 32 bits each
    input  logic [287:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // distance in bits 30:0, bit 31 is zero
    output logic [31:0]  o_m_tdata,
    // hit
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import rts_pkg::*;

    t_pt    r_org;
    t_pt    r_dir;
    t_q     r_min;
    t_pt    c0;
    t_pt    c1;
    t_pt    c2;
    logic   x_valid;
    logic   x_ready;
    t_vec   x_e1;
    t_vec   x_w;
    t_xvec  x_c1;
    t_xvec  x_c2;
    t_xvec  x_c3;
    logic   d_valid;
    logic   d_ready;
    t_dots  d_dots;
    logic   hit;
    t_q     distance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '0;
            r_dir <= '0;
            r_min <= MIN_DIST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ORG_X:    r_org.x <= i_cfg_data;
                REG_ORG_Y:    r_org.y <= i_cfg_data;
                REG_ORG_Z:    r_org.z <= i_cfg_data;
                REG_DIR_X:    r_dir.x <= i_cfg_data;
                REG_DIR_Y:    r_dir.y <= i_cfg_data;
                REG_DIR_Z:    r_dir.z <= i_cfg_data;
                REG_MIN_DIST: r_min   <= i_cfg_data[QW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        c0.x = i_s_tdata[31:0];
        c0.y = i_s_tdata[63:32];
        c0.z = i_s_tdata[95:64];
        c1.x = i_s_tdata[127:96];
        c1.y = i_s_tdata[159:128];
        c1.z = i_s_tdata[191:160];
        c2.x = i_s_tdata[223:192];
        c2.y = i_s_tdata[255:224];
        c2.z = i_s_tdata[287:256];
    end

    rts_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_c0    (c0),
        .i_c1    (c1),
        .i_c2    (c2),
        .i_org   (r_org),
        .i_dir   (r_dir),
        .o_valid (x_valid),
        .i_ready (x_ready),
        .o_e1    (x_e1),
        .o_w     (x_w),
        .o_c1    (x_c1),
        .o_c2    (x_c2),
        .o_c3    (x_c3)
    );

    rts_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_ready (x_ready),
        .i_e1    (x_e1),
        .i_w     (x_w),
        .i_c1    (x_c1),
        .i_c2    (x_c2),
        .i_c3    (x_c3),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_dots  (d_dots)
    );

    rts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (d_ready),
        .i_dots  (d_dots),
        .i_min   (r_min),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_hit   (hit),
        .o_dist  (distance)
    );

    assign o_m_tdata = {1'b0, distance};
    assign o_m_tuser = hit;

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("Input stalled while the output was free.");

    a_miss_zero_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("Miss beat carries a nonzero distance.");

endmodule
